@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the encoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on clk_i, off while rst_ni is low
`define RLEE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on clk_i at every edge, reset included
`define RLEE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/rlee_pkg.sv @@
// Types and constants of the run-length escape encoder
`default_nettype none

package rlee_pkg;

  localparam logic [7:0] EscapeReset = 8'h24;
  localparam logic [3:0] CapReset    = 4'd9;
  localparam logic [3:0] CapLow      = 4'd2;
  localparam logic [3:0] CapHigh     = 4'd9;
  localparam logic [7:0] DigitZero   = 8'h30;
  localparam int unsigned FifoDepth  = 4;

  localparam logic CfgEscape = 1'b0;
  localparam logic CfgCap    = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
  } out_word_t;

  // Up to three coded bytes of one item, count is 1 to 3
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
  } job_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } fifo_stat_t;

  function automatic logic [7:0] digit(input logic [3:0] cnt);
    digit = DigitZero + {4'b0000, cnt};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/rlee_front.sv @@
// Front end: register file, run tracking and job building
`default_nettype none
`include "assert_macros.svh"

module rlee_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire rlee_pkg::in_word_t in_word_i,
  input  wire rlee_pkg::fifo_stat_t fifo_stat_i,
  output logic                    push_o,
  output rlee_pkg::job_t          job_o
);

  logic [7:0] escape_q;
  logic [3:0] max_rep_q;
  logic       have_prev_q, have_prev_d;
  logic [7:0] prev_q, prev_d;
  logic [3:0] rep_q, rep_d;
  logic       cap_q, cap_d;

  logic [3:0] eff_cap;
  logic [3:0] rep_inc;
  logic [1:0] flush_n;
  logic [7:0] flush_b0, flush_b1;
  logic       accept;
  rlee_pkg::job_t job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q  <= rlee_pkg::EscapeReset;
      max_rep_q <= rlee_pkg::CapReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rlee_pkg::CfgEscape: escape_q  <= cfg_wdata_i;
        rlee_pkg::CfgCap:    max_rep_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign eff_cap = (max_rep_q < rlee_pkg::CapLow)  ? rlee_pkg::CapLow  :
                   (max_rep_q > rlee_pkg::CapHigh) ? rlee_pkg::CapHigh : max_rep_q;
  assign rep_inc = rep_q + 4'd1;

  always_comb begin
    flush_n  = 2'd0;
    flush_b0 = escape_q;
    flush_b1 = rlee_pkg::digit(rep_q);
    if (have_prev_q && rep_q == 4'd1) begin
      flush_n  = 2'd1;
      flush_b0 = prev_q;
    end else if (have_prev_q && rep_q >= 4'd2) begin
      flush_n  = 2'd2;
    end
  end

  always_comb begin
    have_prev_d = have_prev_q;
    prev_d      = prev_q;
    rep_d       = rep_q;
    cap_d       = cap_q;
    job.bytes   = {in_word_i.data_byte, flush_b1, flush_b0};
    job.count   = 2'd0;
    if (in_word_i.end_of_stream) begin
      job.count   = flush_n;
      have_prev_d = 1'b0;
      prev_d      = 8'h00;
      rep_d       = 4'd0;
      cap_d       = 1'b0;
    end else if (!have_prev_q || in_word_i.data_byte != prev_q || cap_q) begin
      case (flush_n)
        2'd0:    job.bytes[0] = in_word_i.data_byte;
        2'd1:    job.bytes[1] = in_word_i.data_byte;
        default: job.bytes[2] = in_word_i.data_byte;
      endcase
      job.count   = flush_n + 2'd1;
      have_prev_d = 1'b1;
      prev_d      = in_word_i.data_byte;
      rep_d       = 4'd0;
      cap_d       = 1'b0;
    end else if (rep_inc >= eff_cap) begin
      job.bytes[0] = escape_q;
      job.bytes[1] = rlee_pkg::digit(rep_inc);
      job.count    = 2'd2;
      rep_d        = 4'd0;
      cap_d        = 1'b1;
    end else begin
      rep_d = rep_inc;
    end
  end

  assign in_stall_o = fifo_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = accept && job.count != 2'd0;
  assign job_o      = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_q      <= 8'h00;
      rep_q       <= 4'd0;
      cap_q       <= 1'b0;
    end else if (accept) begin
      have_prev_q <= have_prev_d;
      prev_q      <= prev_d;
      rep_q       <= rep_d;
      cap_q       <= cap_d;
    end
  end

  `RLEE_ASSERT_ALWAYS(a_cap_clears_count, !cap_q || rep_q == 4'd0, "count left after cap")
  `RLEE_ASSERT_ALWAYS(a_idle_run_empty, have_prev_q || (rep_q == 4'd0 && !cap_q),
                      "run state without open run")

endmodule

`default_nettype wire

@@ rtl/core/rlee_fifo.sv @@
// Job queue between front end and byte sequencer
`default_nettype none
`include "assert_macros.svh"

module rlee_fifo #(
  parameter int unsigned Depth = rlee_pkg::FifoDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire rlee_pkg::job_t   job_i,
  input  wire logic             pop_i,
  output rlee_pkg::job_t        job_o,
  output rlee_pkg::fifo_stat_t  stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rlee_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full      = cnt_q == CntW'(Depth);
  assign stat_o.not_empty = cnt_q != '0;
  assign do_push          = push_i && !stat_o.full;
  assign do_pop           = pop_i && stat_o.not_empty;
  assign job_o            = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  `RLEE_ASSERT(a_no_push_full, !(push_i && stat_o.full), "job dropped at full queue")

endmodule

`default_nettype wire

@@ rtl/core/rlee_back.sv @@
// Byte sequencer: steps through a job and feeds the output register
`default_nettype none
`include "assert_macros.svh"

module rlee_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rlee_pkg::fifo_stat_t fifo_stat_i,
  input  wire rlee_pkg::job_t       job_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output rlee_pkg::out_word_t       out_word_o
);

  logic                cur_valid_q;
  rlee_pkg::job_t      cur_q;
  logic [1:0]          idx_q;
  logic                out_valid_q;
  rlee_pkg::out_word_t out_q;
  logic                out_free, advance, is_last, cur_free;
  logic [7:0]          cur_byte;

  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = cur_valid_q && out_free;
  assign is_last  = (idx_q + 2'd1) == cur_q.count;
  assign cur_free = !cur_valid_q || (advance && is_last);
  assign pop_o    = fifo_stat_i.not_empty && cur_free;

  always_comb begin
    case (idx_q)
      2'd0:    cur_byte = cur_q.bytes[0];
      2'd1:    cur_byte = cur_q.bytes[1];
      default: cur_byte = cur_q.bytes[2];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_valid_q <= 1'b1;
        idx_q       <= 2'd0;
      end else if (advance) begin
        cur_valid_q <= !is_last;
        idx_q       <= idx_q + 2'd1;
      end
      if (out_free) begin
        out_valid_q <= cur_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
    end
    if (advance) begin
      out_q.out_byte     <= cur_byte;
      out_q.last_of_item <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `RLEE_ASSERT(a_job_not_empty, !cur_valid_q || cur_q.count != 2'd0, "empty job in sequencer")
  `RLEE_ASSERT(a_idx_in_job, !cur_valid_q || idx_q < cur_q.count, "byte index past job end")

endmodule

`default_nettype wire

@@ rtl/core/run_length_escape_encoder_unit.sv @@
// Top level of the run-length escape encoder
//
//   port group   dir  handshake             payload
//   cfg          in   cfg_we_i              cfg_index_i, cfg_wdata_i
//   in           in   in_valid_i/in_stall_o in_word_i (data_byte, end_of_stream)
//   out          out  out_valid_o/out_stall_i out_word_o (out_byte, last_of_item)
//
// One input word per cycle while the job queue has room; one coded byte per cycle out
// while out_stall_i is low. A coded item's first byte goes through the job queue, the
// sequencer's job register and the output register. Counted repeats code nothing and
// use no queue slot. Input stalls only when the FifoDepth-entry job queue is full.
// Reset is asynchronous; it empties the queue and restores the register reset values.
`default_nettype none

module run_length_escape_encoder_unit #(
  parameter int unsigned FifoDepth = rlee_pkg::FifoDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_index_i,
  input  wire logic [7:0]          cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire rlee_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output rlee_pkg::out_word_t      out_word_o
);

  logic                 push, pop;
  rlee_pkg::job_t       job_in, job_head;
  rlee_pkg::fifo_stat_t fifo_stat;

  rlee_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .job_o       (job_in)
  );

  rlee_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_head),
    .stat_o (fifo_stat)
  );

  rlee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .job_i       (job_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

@@ sim/rlee_checker.sv @@
`timescale 1ns / 1ps
// Checker for the run-length escape encoder: predicts each coded word and compares the output
module rlee_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [7:0]                    cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  rlee_pkg::in_word_t            in_word_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  rlee_pkg::out_word_t           out_word_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  logic [7:0]          escape_q;
  logic [3:0]          cap_q;
  logic                run_open;
  logic [7:0]          run_byte;
  logic [3:0]          repeat_cnt;
  logic                run_capped;
  logic [7:0]          coded_q[$];
  rlee_pkg::out_word_t expected_q[$];

  function automatic logic [3:0] cap_limit(input logic [3:0] cap);
    if (cap < rlee_pkg::CapLow) return rlee_pkg::CapLow;
    if (cap > rlee_pkg::CapHigh) return rlee_pkg::CapHigh;
    return cap;
  endfunction

  task automatic put_count(input logic [3:0] cnt);
    coded_q.push_back(escape_q);
    coded_q.push_back(rlee_pkg::DigitZero + {4'b0000, cnt});
  endtask

  task automatic flush_run();
    if (run_open) begin
      if (repeat_cnt == 4'd1) begin
        coded_q.push_back(run_byte);
      end else if (repeat_cnt >= 4'd2) begin
        put_count(repeat_cnt);
      end
      repeat_cnt = '0;
    end
  endtask

  task automatic encode_word(input rlee_pkg::in_word_t w);
    rlee_pkg::out_word_t exp_w;
    if (w.end_of_stream) begin
      flush_run();
      run_open   = 1'b0;
      run_byte   = '0;
      repeat_cnt = '0;
      run_capped = 1'b0;
    end else if (!run_open || w.data_byte != run_byte || run_capped) begin
      flush_run();
      coded_q.push_back(w.data_byte);
      run_open   = 1'b1;
      run_byte   = w.data_byte;
      repeat_cnt = '0;
      run_capped = 1'b0;
    end else begin
      repeat_cnt = repeat_cnt + 4'd1;
      if (repeat_cnt >= cap_limit(cap_q)) begin
        put_count(repeat_cnt);
        repeat_cnt = '0;
        run_capped = 1'b1;
      end
    end
    while (coded_q.size() > 0) begin
      exp_w.out_byte     = coded_q.pop_front();
      exp_w.last_of_item = (coded_q.size() == 0);
      expected_q.push_back(exp_w);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rlee_pkg::out_word_t exp_w;
    if (!rst_ni) begin
      escape_q     = rlee_pkg::EscapeReset;
      cap_q        = rlee_pkg::CapReset;
      run_open     = 1'b0;
      run_byte     = '0;
      repeat_cnt   = '0;
      run_capped   = 1'b0;
      coded_q.delete();
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word, got out_byte %02h last_of_item %0b",
                   $time, out_word_i.out_byte, out_word_i.last_of_item);
          fail_count_o = fail_count_o + 1;
        end else begin
          exp_w = expected_q.pop_front();
          if (out_word_i.out_byte !== exp_w.out_byte) begin
            $display("%0t: out_byte expected %02h, got %02h",
                     $time, exp_w.out_byte, out_word_i.out_byte);
            fail_count_o = fail_count_o + 1;
          end
          if (out_word_i.last_of_item !== exp_w.last_of_item) begin
            $display("%0t: last_of_item expected %0b, got %0b",
                     $time, exp_w.last_of_item, out_word_i.last_of_item);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        encode_word(in_word_i);
      end
      if (cfg_we_i) begin
        if (cfg_index_i == rlee_pkg::CfgEscape) begin
          escape_q = cfg_wdata_i;
        end else begin
          cap_q = cfg_wdata_i[3:0];
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Testbench top: drives bursty byte streams and register writes into the encoder, gives the verdict
module tb;

  localparam int LongHold      = 48;
  localparam int SettleCycles  = 6;
  localparam int WatchdogLimit = 2000;

  typedef enum int {StallNone, StallHalf, StallThird, StallRare} stall_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_index_i;
  logic [7:0]          cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  rlee_pkg::in_word_t  in_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  rlee_pkg::out_word_t out_word_o;

  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   burst_left;
  logic hold_req;
  logic gaps_on;

  run_length_escape_encoder_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  rlee_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_i  (out_word_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : receiver
    stall_mode_e mode;
    int left;
    logic held;
    out_stall_i = 1'b0;
    mode = StallNone;
    left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(negedge clk_i);
        held = 1'b1;
      end
      if (left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        left = $urandom_range(8, 40);
      end
      left = left - 1;
      case (mode)
        StallNone:  out_stall_i <= 1'b0;
        StallHalf:  out_stall_i <= ($urandom_range(0, 1) == 1);
        StallThird: out_stall_i <= (left % 3 == 0);
        default:    out_stall_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic sender_idle(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i                <= 1'b0;
      in_word_i.data_byte       <= 8'($urandom_range(0, 255));
      in_word_i.end_of_stream   <= 1'($urandom_range(0, 1));
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic eos);
    if (gaps_on && burst_left == 0) begin
      sender_idle($urandom_range(0, 6));
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left = burst_left - 1;
    @(negedge clk_i);
    in_valid_i              <= 1'b1;
    in_word_i.data_byte     <= b;
    in_word_i.end_of_stream <= eos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    sender_idle(1);
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_phase(input int n_items, input int max_run);
    int sent;
    int pick;
    int run_len;
    logic [7:0] b;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_word(8'($urandom_range(0, 255)), 1'b1);
        sent = sent + 1;
      end else if (pick < 16) begin
        send_word(8'($urandom_range(0, 255)), 1'b0);
        sent = sent + 1;
      end else begin
        case ($urandom_range(0, 3))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        run_len = $urandom_range(1, max_run);
        repeat (run_len) send_word(b, 1'b0);
        sent = sent + run_len;
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] b;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = rlee_pkg::CfgEscape;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    hold_req    = 1'b0;
    gaps_on     = 1'b1;
    burst_left  = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: empty end, single repeat, double repeat, end flush, bare end
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(8'h7E, 1'b0);
    send_word(8'h5A, 1'b1);
    drain();

    // cap below range, restart after the cap on an equal byte
    write_reg(rlee_pkg::CfgEscape, 8'h00);
    write_reg(rlee_pkg::CfgCap, 8'h00);
    repeat (5) send_word(8'h55, 1'b0);
    send_word(8'hFF, 1'b1);
    drain();

    write_reg(rlee_pkg::CfgEscape, 8'hFF);
    write_reg(rlee_pkg::CfgCap, 8'h01);
    repeat (3) send_word(8'hAA, 1'b0);
    send_word(8'h00, 1'b1);
    drain();

    write_reg(rlee_pkg::CfgEscape, rlee_pkg::EscapeReset);
    write_reg(rlee_pkg::CfgCap, {4'h0, rlee_pkg::CapReset});
    random_phase(50, 12);
    drain();

    // fill the job queue while the output holds off
    write_reg(rlee_pkg::CfgEscape, 8'($urandom_range(0, 255)));
    write_reg(rlee_pkg::CfgCap, 8'h03);
    hold_req = 1'b1;
    gaps_on  = 1'b0;
    for (int i = 0; i < 16; i++) begin
      b = 8'(i * 17 + 3);
      send_word(b, 1'b0);
    end
    gaps_on = 1'b1;
    random_phase(40, 6);
    drain();

    // cap above range
    write_reg(rlee_pkg::CfgEscape, 8'($urandom_range(0, 255)));
    write_reg(rlee_pkg::CfgCap, 8'hAF);
    random_phase(40, 12);
    drain();

    write_reg(rlee_pkg::CfgEscape, 8'($urandom_range(0, 255)));
    write_reg(rlee_pkg::CfgCap, 8'($urandom_range(0, 255)));
    random_phase(40, 11);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
